FILE: rtl/tmk_pkg.sv
// Shared types, constants and saturation helpers for the thin multipole kick unit.
package tmk_pkg;

  localparam int MAX_ORDERS  = 3;
  localparam int KICK_ORDERS = 3;
  localparam int NUM_COEFS   = 2 * MAX_ORDERS;
  localparam int DIV_LANES   = 4 * KICK_ORDERS;
  localparam int DIV_STEPS   = 33;
  localparam int SQ_STEPS    = 31;
  localparam int ADDR_W      = 5;

  // lane code within one order: lane = 4*order + code
  localparam int LANE_NRE = 0;
  localparam int LANE_NIM = 1;
  localparam int LANE_SRE = 2;
  localparam int LANE_SIM = 3;

  localparam logic [30:0]        LIMIT_RST  = 31'd107374182;
  localparam logic signed [33:0] ONE_Q30_34 = 34'sd1073741824;
  localparam logic signed [63:0] ONE_Q60    = 64'sd1152921504606846976;
  localparam logic signed [64:0] POW_MAX_65 = 65'sd2147483647;
  localparam logic signed [37:0] ONE_Q30_38 = 38'sd1073741824;
  localparam logic [32:0]        TERM_MAX   = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    REG_NORMAL1 = 3'd0,
    REG_NORMAL2 = 3'd1,
    REG_NORMAL3 = 3'd2,
    REG_SKEW1   = 3'd3,
    REG_SKEW2   = 3'd4,
    REG_SKEW3   = 3'd5,
    REG_LIMIT   = 3'd6,
    REG_THRESH  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0]        momentum;
    logic [30:0]        step_length;
  } tmk_in_t;

  typedef struct packed {
    logic signed [31:0] new_z;
    logic signed [31:0] new_dir_x;
    logic signed [31:0] new_dir_y;
    logic signed [31:0] new_dir_z;
    logic               kicked;
  } tmk_out_t;

  // per-item data that rides along the pipeline
  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] new_z;
    logic               kick;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] xp1;
    logic signed [31:0] yp1;
    logic               neg;
  } sq_side_t;

  function automatic logic signed [31:0] sat_pow(input logic signed [64:0] v);
    if (v > POW_MAX_65) return 32'sd2147483647;
    else if (v < -POW_MAX_65) return -32'sd2147483647;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_one(input logic signed [37:0] v);
    if (v > ONE_Q30_38) return 32'sd1073741824;
    else if (v < -ONE_Q30_38) return -32'sd1073741824;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_word(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -33'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

FILE: rtl/tmk_div_pipe.sv
// Pipelined restoring divider lanes: truncating signed quotient, saturated to +-2^32.
module tmk_div_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [63:0]  in_dvd [tmk_pkg::DIV_LANES],
  input  logic [31:0]         in_dvs,
  input  tmk_pkg::side_t      in_side,
  output logic                out_valid,
  output logic signed [33:0]  out_quo [tmk_pkg::DIV_LANES],
  output tmk_pkg::side_t      out_side
);

  localparam int S = tmk_pkg::DIV_STEPS;
  localparam int L = tmk_pkg::DIV_LANES;

  logic [S:0]         vld_r;
  logic [31:0]        rem_r   [S+1][L];
  logic [31:0]        rem_nxt [S+1][L];
  logic [32:0]        lo_r    [S+1][L];
  logic [32:0]        lo_nxt  [S+1][L];
  logic [L-1:0]       neg_r   [S+1];
  logic [L-1:0]       neg_nxt [S+1];
  logic [L-1:0]       ovf_r   [S+1];
  logic [L-1:0]       ovf_nxt [S+1];
  logic [31:0]        dvs_r   [S+1];
  tmk_pkg::side_t     side_r  [S+1];

  logic               out_vld_r;
  logic signed [33:0] quo_r   [L];
  logic signed [33:0] quo_nxt [L];
  tmk_pkg::side_t     oside_r;

  always_comb begin : step_logic
    logic [62:0] mag;
    logic [32:0] t;
    logic        ge;
    mag = '0;
    t   = '0;
    ge  = 1'b0;
    // prep: magnitude, overflow check, upper bits seed the remainder
    for (int l = 0; l < L; l++) begin
      mag = in_dvd[l][63] ? 63'(-in_dvd[l]) : in_dvd[l][62:0];
      neg_nxt[0][l] = in_dvd[l][63];
      ovf_nxt[0][l] = {2'b00, mag[62:33]} >= in_dvs;
      rem_nxt[0][l] = {2'b00, mag[62:33]};
      lo_nxt[0][l]  = mag[32:0];
    end
    // one quotient bit a stage, shifted into the low word
    for (int s = 1; s <= S; s++) begin
      neg_nxt[s] = neg_r[s-1];
      ovf_nxt[s] = ovf_r[s-1];
      for (int l = 0; l < L; l++) begin
        t  = {rem_r[s-1][l], lo_r[s-1][l][32]};
        ge = t >= {1'b0, dvs_r[s-1]};
        rem_nxt[s][l] = ge ? 32'(t - {1'b0, dvs_r[s-1]}) : t[31:0];
        lo_nxt[s][l]  = {lo_r[s-1][l][31:0], ge};
      end
    end
  end

  always_comb begin : final_logic
    logic [32:0] q;
    q = '0;
    for (int l = 0; l < L; l++) begin
      q = (ovf_r[S][l] || lo_r[S][l] > tmk_pkg::TERM_MAX) ? tmk_pkg::TERM_MAX : lo_r[S][l];
      quo_nxt[l] = neg_r[S][l] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[S-1:0], in_valid};
      out_vld_r <= vld_r[S];
    end
  end

  always_ff @(posedge clk) begin
    dvs_r[0]  <= in_dvs;
    side_r[0] <= in_side;
    for (int s = 0; s <= S; s++) begin
      rem_r[s] <= rem_nxt[s];
      lo_r[s]  <= lo_nxt[s];
      neg_r[s] <= neg_nxt[s];
      ovf_r[s] <= ovf_nxt[s];
    end
    for (int s = 1; s <= S; s++) begin
      dvs_r[s]  <= dvs_r[s-1];
      side_r[s] <= side_r[s-1];
    end
    quo_r   <= quo_nxt;
    oside_r <= side_r[S];
  end

  assign out_valid = out_vld_r;
  assign out_quo   = quo_r;
  assign out_side  = oside_r;

endmodule

FILE: rtl/thin_multipole_kick_unit.sv
// Thin multipole kick unit: power series, pipelined division, kick and square-root pipeline.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 33-stage quotient pipeline and the 31-stage square-root pipeline.
// Reset clears all valid bits and loads the register defaults (paraxial limit 0.1).
// Results are strobed for one cycle on out_valid; the receiver cannot hold them off.
module thin_multipole_kick_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tmk_pkg::tmk_in_t            in_item,
  output logic                        out_valid,
  output tmk_pkg::tmk_out_t           out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmk_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int L  = tmk_pkg::DIV_LANES;
  localparam int SQ = tmk_pkg::SQ_STEPS;

  // configuration
  logic signed [31:0] coef_r [tmk_pkg::NUM_COEFS];
  logic [30:0]        limit_r;
  logic [30:0]        thresh_r;
  tmk_pkg::reg_idx_t  reg_idx;

  assign reg_idx = tmk_pkg::reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tmk_pkg::NUM_COEFS; i++) coef_r[i] <= '0;
      limit_r  <= tmk_pkg::LIMIT_RST;
      thresh_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        tmk_pkg::REG_NORMAL1: coef_r[0] <= pwdata;
        tmk_pkg::REG_NORMAL2: coef_r[1] <= pwdata;
        tmk_pkg::REG_NORMAL3: coef_r[2] <= pwdata;
        tmk_pkg::REG_SKEW1:   coef_r[3] <= pwdata;
        tmk_pkg::REG_SKEW2:   coef_r[4] <= pwdata;
        tmk_pkg::REG_SKEW3:   coef_r[5] <= pwdata;
        tmk_pkg::REG_LIMIT:   limit_r   <= pwdata[30:0];
        tmk_pkg::REG_THRESH:  thresh_r  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tmk_pkg::REG_NORMAL1: prdata = coef_r[0];
      tmk_pkg::REG_NORMAL2: prdata = coef_r[1];
      tmk_pkg::REG_NORMAL3: prdata = coef_r[2];
      tmk_pkg::REG_SKEW1:   prdata = coef_r[3];
      tmk_pkg::REG_SKEW2:   prdata = coef_r[4];
      tmk_pkg::REG_SKEW3:   prdata = coef_r[5];
      tmk_pkg::REG_LIMIT:   prdata = {1'b0, limit_r};
      tmk_pkg::REG_THRESH:  prdata = {1'b0, thresh_r};
      default:              prdata = '0;
    endcase
  end

  // stage 0: capture request
  logic              vld0_r;
  tmk_pkg::tmk_in_t  it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else        vld0_r <= start && !busy;
    it_r <= in_item;
  end

  // stage 1: kick qualification, z advance, first squares
  logic                vld1_r;
  logic signed [63:0]  xx1_r, yy1_r, xy1_r;
  logic signed [31:0]  x1_r, y1_r;
  logic [31:0]         p1_r;
  tmk_pkg::side_t      side1_nxt, side1_r;

  always_comb begin : qualify
    logic               has_coef;
    logic signed [33:0] zp_e;
    logic signed [33:0] zp_min;
    has_coef = 1'b0;
    for (int k = 0; k < tmk_pkg::KICK_ORDERS; k++) begin
      if (coef_r[k] != '0 || coef_r[tmk_pkg::MAX_ORDERS+k] != '0) has_coef = 1'b1;
    end
    zp_e   = {{2{it_r.dir_z[31]}}, it_r.dir_z};
    zp_min = tmk_pkg::ONE_Q30_34 - $signed({3'b000, limit_r});
    side1_nxt.dir_x = it_r.dir_x;
    side1_nxt.dir_y = it_r.dir_y;
    side1_nxt.dir_z = it_r.dir_z;
    side1_nxt.new_z = tmk_pkg::sat_word($signed({it_r.pos_z[31], it_r.pos_z})
                                        + $signed({2'b00, it_r.step_length}));
    side1_nxt.kick  = has_coef && !(it_r.step_length < thresh_r) && !(zp_e < zp_min)
                      && (it_r.momentum != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= vld0_r;
    xx1_r   <= $signed(it_r.pos_x) * $signed(it_r.pos_x);
    yy1_r   <= $signed(it_r.pos_y) * $signed(it_r.pos_y);
    xy1_r   <= $signed(it_r.pos_x) * $signed(it_r.pos_y);
    x1_r    <= it_r.pos_x;
    y1_r    <= it_r.pos_y;
    p1_r    <= it_r.momentum;
    side1_r <= side1_nxt;
  end

  // stage 2: w^2 in Q2.30
  logic                vld2_r;
  logic signed [31:0]  pre1_2_r, pim1_2_r, x2_r, y2_r;
  logic [31:0]         p2_r;
  tmk_pkg::side_t      side2_r;
  logic signed [64:0]  d_re2, d_im2;

  assign d_re2 = ($signed({xx1_r[63], xx1_r}) - $signed({yy1_r[63], yy1_r})) >>> 30;
  assign d_im2 = $signed({xy1_r[63], xy1_r}) >>> 29;

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else        vld2_r <= vld1_r;
    pre1_2_r <= tmk_pkg::sat_pow(d_re2);
    pim1_2_r <= tmk_pkg::sat_pow(d_im2);
    x2_r     <= x1_r;
    y2_r     <= y1_r;
    p2_r     <= p1_r;
    side2_r  <= side1_r;
  end

  // stage 3: products for w^3
  logic                vld3_r;
  logic signed [63:0]  ma3_r, mb3_r, mc3_r, md3_r;
  logic signed [31:0]  pre1_3_r, pim1_3_r, x3_r, y3_r;
  logic [31:0]         p3_r;
  tmk_pkg::side_t      side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld3_r <= 1'b0;
    else        vld3_r <= vld2_r;
    ma3_r    <= pre1_2_r * x2_r;
    mb3_r    <= pim1_2_r * y2_r;
    mc3_r    <= pre1_2_r * y2_r;
    md3_r    <= pim1_2_r * x2_r;
    pre1_3_r <= pre1_2_r;
    pim1_3_r <= pim1_2_r;
    x3_r     <= x2_r;
    y3_r     <= y2_r;
    p3_r     <= p2_r;
    side3_r  <= side2_r;
  end

  // stage 4: w^3 in Q2.30, powers gathered by order
  logic                vld4_r;
  logic signed [31:0]  pre4_r [tmk_pkg::MAX_ORDERS];
  logic signed [31:0]  pim4_r [tmk_pkg::MAX_ORDERS];
  logic [31:0]         p4_r;
  tmk_pkg::side_t      side4_r;
  logic signed [64:0]  d_re4, d_im4;

  assign d_re4 = ($signed({ma3_r[63], ma3_r}) - $signed({mb3_r[63], mb3_r})) >>> 30;
  assign d_im4 = ($signed({mc3_r[63], mc3_r}) + $signed({md3_r[63], md3_r})) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) vld4_r <= 1'b0;
    else        vld4_r <= vld3_r;
    pre4_r[0] <= x3_r;
    pim4_r[0] <= y3_r;
    pre4_r[1] <= pre1_3_r;
    pim4_r[1] <= pim1_3_r;
    pre4_r[2] <= tmk_pkg::sat_pow(d_re4);
    pim4_r[2] <= tmk_pkg::sat_pow(d_im4);
    p4_r      <= p3_r;
    side4_r   <= side3_r;
  end

  // stage 5: coefficient times power, one lane per term
  logic                vld5_r;
  logic signed [63:0]  prod5_r   [L];
  logic signed [63:0]  prod5_nxt [L];
  logic [31:0]         p5_r;
  tmk_pkg::side_t      side5_r;

  always_comb begin
    for (int l = 0; l < L; l++) prod5_nxt[l] = '0;
    for (int k = 0; k < tmk_pkg::KICK_ORDERS; k++) begin
      prod5_nxt[4*k + tmk_pkg::LANE_NRE] = coef_r[k] * pre4_r[k];
      prod5_nxt[4*k + tmk_pkg::LANE_NIM] = coef_r[k] * pim4_r[k];
      prod5_nxt[4*k + tmk_pkg::LANE_SRE] = coef_r[tmk_pkg::MAX_ORDERS+k] * pre4_r[k];
      prod5_nxt[4*k + tmk_pkg::LANE_SIM] = coef_r[tmk_pkg::MAX_ORDERS+k] * pim4_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld5_r <= 1'b0;
    else        vld5_r <= vld4_r;
    prod5_r <= prod5_nxt;
    p5_r    <= p4_r;
    side5_r <= side4_r;
  end

  // divide every term by the momentum
  logic                dvld;
  logic signed [33:0]  dquo [L];
  tmk_pkg::side_t      dside;

  tmk_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld5_r),
    .in_dvd    (prod5_r),
    .in_dvs    (p5_r),
    .in_side   (side5_r),
    .out_valid (dvld),
    .out_quo   (dquo),
    .out_side  (dside)
  );

  // stage 6: term sums
  logic                vld6_r;
  logic signed [36:0]  sx6_nxt, sy6_nxt, sx6_r, sy6_r;
  tmk_pkg::side_t      side6_r;

  always_comb begin
    sx6_nxt = '0;
    sy6_nxt = '0;
    for (int k = 0; k < tmk_pkg::KICK_ORDERS; k++) begin
      sx6_nxt = sx6_nxt + 37'(dquo[4*k + tmk_pkg::LANE_NRE])
                        + 37'(dquo[4*k + tmk_pkg::LANE_SIM]);
      sy6_nxt = sy6_nxt + 37'(dquo[4*k + tmk_pkg::LANE_NIM])
                        + 37'(dquo[4*k + tmk_pkg::LANE_SRE]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld6_r <= 1'b0;
    else        vld6_r <= dvld;
    sx6_r   <= sx6_nxt;
    sy6_r   <= sy6_nxt;
    side6_r <= dside;
  end

  // stage 7: apply the kick
  logic                vld7_r;
  logic signed [31:0]  xp7_r, yp7_r;
  tmk_pkg::side_t      side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld7_r <= 1'b0;
    else        vld7_r <= vld6_r;
    xp7_r   <= tmk_pkg::sat_one(38'(side6_r.dir_x) - 38'(sx6_r));
    yp7_r   <= tmk_pkg::sat_one(38'(side6_r.dir_y) + 38'(sy6_r));
    side7_r <= side6_r;
  end

  // stage 8: squares of the new slopes
  logic                vld8_r;
  logic signed [63:0]  sqx8_r, sqy8_r;
  logic signed [31:0]  xp8_r, yp8_r;
  tmk_pkg::side_t      side8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld8_r <= 1'b0;
    else        vld8_r <= vld7_r;
    sqx8_r  <= xp7_r * xp7_r;
    sqy8_r  <= yp7_r * yp7_r;
    xp8_r   <= xp7_r;
    yp8_r   <= yp7_r;
    side8_r <= side7_r;
  end

  // square-root pipeline, one result bit a stage
  logic [SQ:0]          sq_vld_r;
  logic [61:0]          v_r     [SQ+1];
  logic [61:0]          v_nxt   [SQ+1];
  logic [61:0]          res_r   [SQ+1];
  logic [61:0]          res_nxt [SQ+1];
  tmk_pkg::sq_side_t    sqs_r   [SQ+1];
  tmk_pkg::sq_side_t    sqs0_nxt;
  logic signed [63:0]   rad;

  assign rad = tmk_pkg::ONE_Q60 - sqx8_r - sqy8_r;

  always_comb begin : sqrt_logic
    logic [61:0] bitv;
    logic [61:0] trial;
    bitv  = '0;
    trial = '0;
    sqs0_nxt.side = side8_r;
    sqs0_nxt.xp1  = xp8_r;
    sqs0_nxt.yp1  = yp8_r;
    sqs0_nxt.neg  = rad[63];
    v_nxt[0]   = rad[61:0];
    res_nxt[0] = '0;
    for (int s = 1; s <= SQ; s++) begin
      bitv  = 62'(1) << (62 - 2*s);
      trial = res_r[s-1] + bitv;
      if (v_r[s-1] >= trial) begin
        v_nxt[s]   = v_r[s-1] - trial;
        res_nxt[s] = (res_r[s-1] >> 1) + bitv;
      end else begin
        v_nxt[s]   = v_r[s-1];
        res_nxt[s] = res_r[s-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r <= '0;
    else        sq_vld_r <= {sq_vld_r[SQ-1:0], vld8_r};
    sqs_r[0] <= sqs0_nxt;
    for (int s = 1; s <= SQ; s++) sqs_r[s] <= sqs_r[s-1];
    for (int s = 0; s <= SQ; s++) begin
      v_r[s]   <= v_nxt[s];
      res_r[s] <= res_nxt[s];
    end
  end

  // output stage: exit check and result select
  logic                out_vld_r;
  tmk_pkg::tmk_out_t   out_r, out_nxt;
  tmk_pkg::sq_side_t   fin;
  logic signed [32:0]  zp1;
  logic                kick_fin;

  assign fin      = sqs_r[SQ];
  assign zp1      = fin.neg ? {fin.side.dir_z[31], fin.side.dir_z}
                            : $signed({2'b00, res_r[SQ][30:0]});
  assign kick_fin = fin.side.kick && (zp1 >= $signed({2'b00, limit_r}));

  always_comb begin
    out_nxt.new_z = fin.side.new_z;
    if (kick_fin) begin
      out_nxt.new_dir_x = fin.xp1;
      out_nxt.new_dir_y = fin.yp1;
      out_nxt.new_dir_z = zp1[31:0];
      out_nxt.kicked    = 1'b1;
    end else begin
      out_nxt.new_dir_x = fin.side.dir_x;
      out_nxt.new_dir_y = fin.side.dir_y;
      out_nxt.new_dir_z = fin.side.dir_z;
      out_nxt.kicked    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= sq_vld_r[SQ];
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

FILE: verif/thin_multipole_kick_unit_tb.sv
// Testbench for the thin multipole kick unit: directed and random particles against a predictor.
`timescale 1ns / 100ps

module thin_multipole_kick_unit_tb;

  localparam int LATENCY = 76;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tmk_pkg::tmk_in_t in_item;
  logic out_valid;
  tmk_pkg::tmk_out_t out_item;
  logic psel, penable, pwrite;
  logic [tmk_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  thin_multipole_kick_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the registers
  logic signed [31:0] normal_coef [3];
  logic signed [31:0] skew_coef [3];
  logic [30:0] paraxial_limit;
  logic [30:0] length_threshold;

  tmk_pkg::tmk_out_t kick_queue[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic tmk_pkg::tmk_out_t kick_particle(tmk_pkg::tmk_in_t it);
    tmk_pkg::tmk_out_t o;
    longint x, y, xp, yp, zp, p, h, xp1, yp1, zp1, rad, one;
    longint pre[3], pim[3];
    longint nre, nim, sre, sim;
    bit has_coef, kick;
    one = 64'sd1073741824;
    x = it.pos_x; y = it.pos_y;
    xp = it.dir_x; yp = it.dir_y; zp = it.dir_z;
    p = {32'd0, it.momentum};
    h = {33'd0, it.step_length};
    o.new_z = 32'(clip(longint'(it.pos_z) + h, -64'sd2147483648, 64'sd2147483647));
    has_coef = 0;
    for (int k = 0; k < tmk_pkg::KICK_ORDERS; k++)
      if (normal_coef[k] != 0 || skew_coef[k] != 0) has_coef = 1;
    kick = has_coef && !(h < longint'(length_threshold)) &&
           !(zp < one - longint'(paraxial_limit)) && p != 0;
    if (kick) begin
      nre = 0; nim = 0; sre = 0; sim = 0;
      pre[0] = x; pim[0] = y;
      pre[1] = clip(floor_shr(x * x - y * y, 30), -64'sd2147483647, 64'sd2147483647);
      pim[1] = clip(floor_shr(x * y, 29), -64'sd2147483647, 64'sd2147483647);
      pre[2] = clip(floor_shr(pre[1] * x - pim[1] * y, 30), -64'sd2147483647, 64'sd2147483647);
      pim[2] = clip(floor_shr(pre[1] * y + pim[1] * x, 30), -64'sd2147483647, 64'sd2147483647);
      for (int k = 0; k < tmk_pkg::KICK_ORDERS; k++) begin
        nre += clip(longint'(normal_coef[k]) * pre[k] / p, -64'sd4294967296, 64'sd4294967296);
        nim += clip(longint'(normal_coef[k]) * pim[k] / p, -64'sd4294967296, 64'sd4294967296);
        sre += clip(longint'(skew_coef[k]) * pre[k] / p, -64'sd4294967296, 64'sd4294967296);
        sim += clip(longint'(skew_coef[k]) * pim[k] / p, -64'sd4294967296, 64'sd4294967296);
      end
      xp1 = clip(xp - (nre + sim), -one, one);
      yp1 = clip(yp + (nim + sre), -one, one);
      rad = one * one - xp1 * xp1 - yp1 * yp1;
      zp1 = rad < 0 ? zp : isqrt(rad);
      if (zp1 < longint'(paraxial_limit)) begin
        kick = 0;
      end else begin
        o.new_dir_x = 32'(xp1);
        o.new_dir_y = 32'(yp1);
        o.new_dir_z = 32'(zp1);
        o.kicked = 1'b1;
      end
    end
    if (!kick) begin
      o.new_dir_x = it.dir_x;
      o.new_dir_y = it.dir_y;
      o.new_dir_z = it.dir_z;
      o.kicked = 1'b0;
    end
    return o;
  endfunction

  task automatic write_reg(tmk_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= tmk_pkg::ADDR_W'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tmk_pkg::REG_NORMAL1, tmk_pkg::REG_NORMAL2, tmk_pkg::REG_NORMAL3:
        normal_coef[int'(idx)] = value;
      tmk_pkg::REG_SKEW1, tmk_pkg::REG_SKEW2, tmk_pkg::REG_SKEW3:
        skew_coef[int'(idx) - int'(tmk_pkg::REG_SKEW1)] = value;
      tmk_pkg::REG_LIMIT: paraxial_limit = value[30:0];
      default: length_threshold = value[30:0];
    endcase
  endtask

  // start stays high between back-to-back requests; drop it only while idling
  task automatic send_particle(tmk_pkg::tmk_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    kick_queue = {kick_queue, kick_particle(it)};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (kick_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(5))
      0: return 32'sd1073741824;
      1: return -32'sd1073741824;
      2: return $urandom;
      default: return $signed(32'($urandom_range(32'h8000_0000)) - 32'd1073741824);
    endcase
  endfunction

  // mostly paraxial particles near the axis, with some wide ones
  function automatic tmk_pkg::tmk_in_t rand_particle();
    tmk_pkg::tmk_in_t it;
    int sh;
    sh = $urandom_range(31);
    it.pos_x = $signed($urandom) >>> sh;
    it.pos_y = $signed($urandom) >>> $urandom_range(31);
    it.pos_z = $urandom;
    if ($urandom_range(3) != 0) begin
      it.dir_x = $signed($urandom) >>> $urandom_range(4, 31);
      it.dir_y = $signed($urandom) >>> $urandom_range(4, 31);
      it.dir_z = 32'sd1073741824 - ($urandom >> $urandom_range(5, 31));
    end else begin
      it.dir_x = rand_dir();
      it.dir_y = rand_dir();
      it.dir_z = rand_dir();
    end
    it.momentum = $urandom_range(7) == 0 ? $urandom : ($urandom >> $urandom_range(31));
    if (it.momentum == 0 && $urandom_range(3) != 0) it.momentum = 1;
    it.step_length = 31'($urandom >> $urandom_range(1, 31));
    return it;
  endfunction

  task automatic load_coefs(logic [31:0] n1, n2, n3, s1, s2, s3);
    write_reg(tmk_pkg::REG_NORMAL1, n1);
    write_reg(tmk_pkg::REG_NORMAL2, n2);
    write_reg(tmk_pkg::REG_NORMAL3, n3);
    write_reg(tmk_pkg::REG_SKEW1, s1);
    write_reg(tmk_pkg::REG_SKEW2, s2);
    write_reg(tmk_pkg::REG_SKEW3, s3);
  endtask

  task automatic test_directed();
    tmk_pkg::tmk_in_t it;
    it = '{pos_x: 32'sd268435456, pos_y: -32'sd134217728, pos_z: 0,
           dir_x: 0, dir_y: 0, dir_z: 32'sd1073741824,
           momentum: 32'd1024, step_length: 31'd1000};
    // zero strength at reset
    send_particle(it);
    drain();
    load_coefs(32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128);
    send_particle(it);
    // saturating z
    it.pos_z = 32'sh7FFF_FFFF; it.step_length = 31'h7FFF_FFFF;
    send_particle(it);
    it.pos_z = 32'sh8000_0000; it.step_length = 0;
    send_particle(it);
    // extreme positions and momentum
    it.pos_x = 32'sh8000_0000; it.pos_y = 32'sh8000_0000; it.momentum = 32'd1;
    send_particle(it);
    it.pos_x = 32'sh7FFF_FFFF; it.pos_y = 32'sh7FFF_FFFF; it.momentum = 32'hFFFF_FFFF;
    send_particle(it);
    it.momentum = 0;
    send_particle(it);
    // non-paraxial entry
    it.momentum = 32'd1; it.dir_z = 32'sd900000000;
    send_particle(it);
    it.dir_z = -32'sd1073741824; it.dir_x = 32'sd1073741824; it.dir_y = -32'sd1073741824;
    send_particle(it);
    // out-of-range directions
    it.dir_z = 32'sh7FFF_FFFF; it.dir_x = 32'sh8000_0000; it.dir_y = 32'sh7FFF_FFFF;
    send_particle(it);
    drain();
    write_reg(tmk_pkg::REG_THRESH, 32'd5000);
    it = '{pos_x: 32'sd1000, pos_y: 32'sd1000, pos_z: 0, dir_x: 0, dir_y: 0,
           dir_z: 32'sd1073741824, momentum: 32'd1, step_length: 31'd4999};
    send_particle(it);
    it.step_length = 31'd5000;
    send_particle(it);
    drain();
    // huge kick drives the radicand negative or zp below the limit
    load_coefs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    write_reg(tmk_pkg::REG_LIMIT, 32'd1073741824);
    send_particle(it);
    drain();
    write_reg(tmk_pkg::REG_LIMIT, 32'd0);
    write_reg(tmk_pkg::REG_THRESH, 32'd0);
    send_particle(it);
    it.pos_x = 32'sd300000000;
    send_particle(it);
    drain();
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_particle(rand_particle());
  endtask

  task automatic test_random();
    logic [31:0] c[6];
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 6; k++)
        c[k] = $urandom_range(2) == 0 ? 0 : ($urandom >> $urandom_range(31));
      load_coefs(c[0], c[1], c[2], c[3], c[4], c[5]);
      write_reg(tmk_pkg::REG_LIMIT, ph == 0 ? 32'd1073741824 : $urandom_range(1073741824));
      write_reg(tmk_pkg::REG_THRESH,
                ph == 1 ? 32'h7FFF_FFFF : ($urandom >> $urandom_range(4, 31)));
      send_idle_pct = ph < 2 ? 28 : (ph < 4 ? 48 : 0);
      random_phase(105);
      drain();
    end
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    load_coefs(32'd65536, 0, 0, 0, 0, 32'd99);
    write_reg(tmk_pkg::REG_LIMIT, 32'd107374182);
    random_phase(20);
    drain();
  endtask

  always @(posedge clk) begin
    tmk_pkg::tmk_out_t want;
    if (rst_n && out_valid) begin
      if (kick_queue.size() == 0) begin
        $error("unexpected result %h", out_item);
        errors++;
      end else begin
        want = kick_queue.pop_front();
        if (out_item.new_z !== want.new_z) begin
          $error("new_z expected %h got %h", want.new_z, out_item.new_z); errors++;
        end
        if (out_item.new_dir_x !== want.new_dir_x) begin
          $error("new_dir_x expected %h got %h", want.new_dir_x, out_item.new_dir_x); errors++;
        end
        if (out_item.new_dir_y !== want.new_dir_y) begin
          $error("new_dir_y expected %h got %h", want.new_dir_y, out_item.new_dir_y); errors++;
        end
        if (out_item.new_dir_z !== want.new_dir_z) begin
          $error("new_dir_z expected %h got %h", want.new_dir_z, out_item.new_dir_z); errors++;
        end
        if (out_item.kicked !== want.kicked) begin
          $error("kicked expected %b got %b", want.kicked, out_item.kicked); errors++;
        end
      end
    end
  end

  // count cycles with no request, result or register access moving
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int k = 0; k < 3; k++) begin
      normal_coef[k] = 0;
      skew_coef[k] = 0;
    end
    paraxial_limit = tmk_pkg::LIMIT_RST;
    length_threshold = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_back_to_back();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
